// File: rtl/jmu_pkg.sv
// Shared codes, widths and pipeline item types of the Jacobian metric unit.
// No dependencies; every other file of the unit uses this package.
`default_nettype none
package jmu_pkg;

	// operation selector codes
	localparam logic [1:0] FUNC_INV  = 2'd0;
	localparam logic [1:0] FUNC_DET  = 2'd1;
	localparam logic [1:0] FUNC_NORM = 2'd2;

	// face rules for the normal
	localparam logic [1:0] FACE_ROW2 = 2'd0;
	localparam logic [1:0] FACE_ROW1 = 2'd1;
	localparam logic [1:0] FACE_SUM  = 2'd2;
	localparam logic [1:0] FACE_ROW0 = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;

	// determinant magnitude width and quotient bits of the inverse divider
	localparam int DET_W   = 96;
	localparam int INV_QW  = 33;
	// normal length width and quotient bits of the unit-normal divider
	localparam int ROOT_W  = 34;
	localparam int UNIT_QW = 17;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	typedef struct packed {
		logic        vld;
		logic [1:0]  func;
		logic [1:0]  face;
		logic [30:0] w;
		logic        dz;
	} tag_t;

	// travels beside the inverse divider
	typedef struct packed {
		tag_t            tag;
		logic            dneg;
		logic [8:0]      eneg;
		logic [8:0]      ovf;
		logic [2:0][62:0] m1pp;
		logic [31:0]     wj1;
		logic            sat1;
	} front_t;

	// travels through the normal, square root and unit-normal stages
	typedef struct packed {
		tag_t             tag;
		logic [8:0][31:0] inv;
		logic             sat;
		logic [31:0]      wj1;
		logic [2:0][33:0] nval;
		logic [2:0][65:0] nsq;
		logic [2:0][32:0] nmag;
		logic [2:0]       nneg;
		logic [67:0]      ssum;
		logic             lz;
		logic [64:0]      wprod;
		logic [31:0]      wj2;
		logic             sat2;
	} back_t;

endpackage
`default_nettype wire

// File: rtl/jmu_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on jmu_pkg for its default widths.
`default_nettype none
module jmu_div_pipe #(
	parameter int DW = jmu_pkg::DET_W,
	parameter int QW = jmu_pkg::INV_QW
) (
	input  wire logic          clk,
	input  wire logic [DW-1:0] rem_in,
	input  wire logic [QW-1:0] feed,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	logic [DW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] feed_s [QW];
	logic [QW-1:0] quo_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] r_prev;
		logic [DW-1:0] d_prev;
		logic [QW-1:0] f_prev;
		logic [QW-1:0] q_prev;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;
		logic [QW-1:0] q_next;

		if (k == 0) begin : g_first
			assign r_prev = rem_in;
			assign d_prev = den;
			assign f_prev = feed;
			assign q_prev = '0;
		end else begin : g_next
			assign r_prev = rem_s[k-1];
			assign d_prev = den_s[k-1];
			assign f_prev = feed_s[k-1];
			assign q_prev = quo_s[k-1];
		end

		// shift in the next dividend bit, subtract when it fits
		always_comb begin
			trial = {r_prev, f_prev[QW-1-k]};
			diff = trial - {1'b0, d_prev};
			ge = trial >= {1'b0, d_prev};
			q_next = q_prev;
			q_next[QW-1-k] = ge;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			den_s[k] <= d_prev;
			feed_s[k] <= f_prev;
			quo_s[k] <= q_next;
		end
	end

	assign quo = quo_s[QW-1];

endmodule
`default_nettype wire

// File: rtl/jacobian_metric_unit.sv
// Jacobian metric unit: takes one beat per clock (busy stays low) and delivers
// its results one result per beat, in order, each
// flagged by done for a single cycle; the receiver cannot hold results off.
// The pipeline holds the 33-stage divider that forms the inverse, the
// 34-stage square root of the normal length and the 17-stage divider of the
// unit normal, each taking one bit or one root digit per register stage.
// Depends on jmu_pkg and jmu_div_pipe.
`default_nettype none
module jacobian_metric_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         func,
	input  wire logic [1:0]         face_select,
	input  wire logic signed [31:0] j00,
	input  wire logic signed [31:0] j01,
	input  wire logic signed [31:0] j02,
	input  wire logic signed [31:0] j10,
	input  wire logic signed [31:0] j11,
	input  wire logic signed [31:0] j12,
	input  wire logic signed [31:0] j20,
	input  wire logic signed [31:0] j21,
	input  wire logic signed [31:0] j22,
	input  wire logic [30:0]        quad_weight,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      m00,
	output logic signed [31:0]      m01,
	output logic signed [31:0]      m02,
	output logic signed [31:0]      m10,
	output logic signed [31:0]      m11,
	output logic signed [31:0]      m12,
	output logic signed [31:0]      m20,
	output logic signed [31:0]      m21,
	output logic signed [31:0]      m22,
	output logic signed [31:0]      weighted_jacobian
);
	import jmu_pkg::*;

	localparam int SQ_STEPS = ROOT_W;
	localparam int FD_LEN = INV_QW;
	localparam int BD_LEN = UNIT_QW;

	assign busy = 1'b0;

	logic signed [31:0] a_w [3][3];
	assign a_w[0][0] = j00;
	assign a_w[0][1] = j01;
	assign a_w[0][2] = j02;
	assign a_w[1][0] = j10;
	assign a_w[1][1] = j11;
	assign a_w[1][2] = j12;
	assign a_w[2][0] = j20;
	assign a_w[2][1] = j21;
	assign a_w[2][2] = j22;

	// stage 1: cofactor products
	tag_t               tag_s1;
	logic signed [63:0] pp_s1 [3][3];
	logic signed [63:0] qp_s1 [3][3];
	logic signed [31:0] arow_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1.vld <= 1'b0;
		end else begin
			tag_s1 <= '{vld: start, func: func, face: face_select, w: quad_weight, dz: 1'b0};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_prod_r
		for (genvar j = 0; j < 3; j++) begin : g_prod_c
			localparam int R1 = (i + 1) % 3;
			localparam int R2 = (i + 2) % 3;
			localparam int C1 = (j + 1) % 3;
			localparam int C2 = (j + 2) % 3;
			always_ff @(posedge clk) begin
				pp_s1[i][j] <= a_w[R1][C1] * a_w[R2][C2];
				qp_s1[i][j] <= a_w[R1][C2] * a_w[R2][C1];
			end
		end
		always_ff @(posedge clk) begin
			arow_s1[i] <= a_w[0][i];
		end
	end

	// stage 2: cofactors
	tag_t               tag_s2;
	logic signed [64:0] cof_s2 [9];
	logic signed [31:0] arow_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2.vld <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_cof
		always_ff @(posedge clk) begin
			cof_s2[e] <= {pp_s1[e/3][e%3][63], pp_s1[e/3][e%3]}
				- {qp_s1[e/3][e%3][63], qp_s1[e/3][e%3]};
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_arow2
		always_ff @(posedge clk) begin
			arow_s2[k] <= arow_s1[k];
		end
	end

	// stage 3: magnitudes and signs
	tag_t        tag_s3;
	logic [63:0] cmag_s3 [9];
	logic [8:0]  cneg_s3;
	logic [31:0] amag_s3 [3];
	logic [2:0]  aneg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3.vld <= 1'b0;
		end else begin
			tag_s3 <= tag_s2;
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_cmag
		logic signed [64:0] ncof;
		assign ncof = -cof_s2[e];
		always_ff @(posedge clk) begin
			cmag_s3[e] <= cof_s2[e][64] ? ncof[63:0] : cof_s2[e][63:0];
			cneg_s3[e] <= cof_s2[e][64];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_amag
		logic [31:0] na;
		assign na = -arow_s2[k];
		always_ff @(posedge clk) begin
			amag_s3[k] <= arow_s2[k][31] ? na : arow_s2[k];
			aneg_s3[k] <= arow_s2[k][31];
		end
	end

	// stage 4: determinant partial products
	tag_t        tag_s4;
	logic [63:0] pplo_s4 [3];
	logic [63:0] pphi_s4 [3];
	logic [2:0]  tneg_s4;
	logic [63:0] cmag_s4 [9];
	logic [8:0]  cneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4.vld <= 1'b0;
		end else begin
			tag_s4 <= tag_s3;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_detpp
		always_ff @(posedge clk) begin
			pplo_s4[k] <= cmag_s3[k][31:0] * amag_s3[k];
			pphi_s4[k] <= cmag_s3[k][63:32] * amag_s3[k];
			tneg_s4[k] <= cneg_s3[k] ^ aneg_s3[k];
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_c4
		always_ff @(posedge clk) begin
			cmag_s4[e] <= cmag_s3[e];
			cneg_s4[e] <= cneg_s3[e];
		end
	end

	// stage 5: signed determinant
	tag_t               tag_s5;
	logic signed [97:0] det_s5;
	logic [63:0]        cmag_s5 [9];
	logic [8:0]         cneg_s5;
	logic signed [97:0] dterm [3];

	for (genvar k = 0; k < 3; k++) begin : g_dterm
		logic [97:0] t;
		assign t = {2'b00, pphi_s4[k], 32'h0} + {34'h0, pplo_s4[k]};
		assign dterm[k] = tneg_s4[k] ? -t : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5.vld <= 1'b0;
		end else begin
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		det_s5 <= dterm[0] + dterm[1] + dterm[2];
	end

	for (genvar e = 0; e < 9; e++) begin : g_c5
		always_ff @(posedge clk) begin
			cmag_s5[e] <= cmag_s4[e];
			cneg_s5[e] <= cneg_s4[e];
		end
	end

	// stage 6: determinant magnitude, overflow screen per inverse entry
	tag_t        tag_s6;
	logic [95:0] dmag_s6;
	logic        dneg_s6;
	logic [63:0] cmag_s6 [9];
	logic [8:0]  eneg_s6;
	logic [8:0]  ovf_s6;
	logic [97:0] ndet;
	logic [95:0] dmag_w;

	assign ndet = -det_s5;
	assign dmag_w = det_s5[97] ? ndet[95:0] : det_s5[95:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s6.vld <= 1'b0;
		end else begin
			tag_s6 <= '{vld: tag_s5.vld, func: tag_s5.func, face: tag_s5.face,
				w: tag_s5.w, dz: (det_s5 == '0)};
		end
	end

	always_ff @(posedge clk) begin
		dmag_s6 <= dmag_w;
		dneg_s6 <= det_s5[97];
	end

	// inverse entry (i,j) divides cofactor (j,i)
	for (genvar e = 0; e < 9; e++) begin : g_ovf
		localparam int SRC = (e % 3) * 3 + e / 3;
		always_ff @(posedge clk) begin
			cmag_s6[e] <= cmag_s5[SRC];
			eneg_s6[e] <= cneg_s5[SRC] ^ det_s5[97];
			ovf_s6[e] <= {33'h0, cmag_s5[SRC]} >= {dmag_w, 1'b0};
		end
	end

	// inverse dividers: cofactor * 2^32 / determinant
	logic [INV_QW-1:0] quo_inv [9];

	for (genvar e = 0; e < 9; e++) begin : g_inv_div
		jmu_div_pipe #(.DW(DET_W), .QW(INV_QW)) u_div (
			.clk    (clk),
			.rem_in ({33'h0, cmag_s6[e][63:1]}),
			.feed   ({cmag_s6[e][0], 32'h0}),
			.den    (dmag_s6),
			.quo    (quo_inv[e])
		);
	end

	// side line beside the inverse divider; mode 1 product forms on the way
	front_t fd_s [FD_LEN];

	for (genvar k = 0; k < FD_LEN; k++) begin : g_fd
		front_t nxt;
		if (k == 0) begin : g_first
			always_comb begin
				nxt = '0;
				nxt.tag = tag_s6;
				nxt.dneg = dneg_s6;
				nxt.eneg = eneg_s6;
				nxt.ovf = ovf_s6;
				for (int p = 0; p < 3; p++) begin
					nxt.m1pp[p] = dmag_s6[32*p +: 32] * tag_s6.w;
				end
			end
		end else if (k == 1) begin : g_m1
			logic [126:0] tot;
			logic [78:0]  r;
			always_comb begin
				tot = {64'h0, fd_s[0].m1pp[0]} + {32'h0, fd_s[0].m1pp[1], 32'h0}
					+ {fd_s[0].m1pp[2], 64'h0};
				r = tot[126:48];
				nxt = fd_s[0];
				if (fd_s[0].dneg) begin
					nxt.sat1 = r > 79'h8000_0000;
					nxt.wj1 = nxt.sat1 ? NEG_MAX : -r[31:0];
				end else begin
					nxt.sat1 = r > 79'h7FFF_FFFF;
					nxt.wj1 = nxt.sat1 ? POS_MAX : r[31:0];
				end
			end
		end else begin : g_copy
			assign nxt = fd_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fd_s[k].tag.vld <= 1'b0;
			end else begin
				fd_s[k] <= nxt;
			end
		end
	end

	// stage 40: sign and saturate the inverse entries
	back_t bk_s40;
	back_t inv_nxt;

	always_comb begin
		logic [INV_QW-1:0] q;
		logic              se;
		logic              sat_any;
		inv_nxt = '0;
		sat_any = 1'b0;
		inv_nxt.tag = fd_s[FD_LEN-1].tag;
		inv_nxt.wj1 = fd_s[FD_LEN-1].wj1;
		for (int e = 0; e < 9; e++) begin
			q = quo_inv[e];
			if (fd_s[FD_LEN-1].eneg[e]) begin
				se = fd_s[FD_LEN-1].ovf[e] || (q > 33'h0_8000_0000);
				inv_nxt.inv[e] = se ? NEG_MAX : -q[31:0];
			end else begin
				se = fd_s[FD_LEN-1].ovf[e] || (q[32:31] != 2'b00);
				inv_nxt.inv[e] = se ? POS_MAX : q[31:0];
			end
			sat_any = sat_any | se;
		end
		inv_nxt.sat = (fd_s[FD_LEN-1].tag.func == FUNC_DET) ? fd_s[FD_LEN-1].sat1 : sat_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_s40.tag.vld <= 1'b0;
		end else begin
			bk_s40 <= inv_nxt;
		end
	end

	// stage 41: face normal from the inverse rows
	back_t bk_s41;
	back_t nrm_nxt;

	always_comb begin
		logic [33:0] r0;
		logic [33:0] r1;
		logic [33:0] r2;
		nrm_nxt = bk_s40;
		for (int k = 0; k < 3; k++) begin
			r0 = {{2{bk_s40.inv[k][31]}}, bk_s40.inv[k]};
			r1 = {{2{bk_s40.inv[3+k][31]}}, bk_s40.inv[3+k]};
			r2 = {{2{bk_s40.inv[6+k][31]}}, bk_s40.inv[6+k]};
			case (bk_s40.tag.face)
				FACE_ROW2: nrm_nxt.nval[k] = -r2;
				FACE_ROW1: nrm_nxt.nval[k] = -r1;
				FACE_SUM:  nrm_nxt.nval[k] = r0 + r1 + r2;
				FACE_ROW0: nrm_nxt.nval[k] = -r0;
				default:   nrm_nxt.nval[k] = -r0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_s41.tag.vld <= 1'b0;
		end else begin
			bk_s41 <= nrm_nxt;
		end
	end

	// stage 42: squares and magnitudes of the normal
	back_t bk_s42;
	back_t sq_nxt;

	always_comb begin
		logic signed [33:0] nv;
		logic signed [67:0] pr;
		logic [33:0]        nn;
		sq_nxt = bk_s41;
		for (int k = 0; k < 3; k++) begin
			nv = bk_s41.nval[k];
			pr = nv * nv;
			nn = -nv;
			sq_nxt.nsq[k] = pr[65:0];
			sq_nxt.nneg[k] = nv[33];
			sq_nxt.nmag[k] = nv[33] ? nn[32:0] : nv[32:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_s42.tag.vld <= 1'b0;
		end else begin
			bk_s42 <= sq_nxt;
		end
	end

	// stage 43: squared length
	back_t bk_s43;
	back_t sum_nxt;

	always_comb begin
		sum_nxt = bk_s42;
		sum_nxt.ssum = {2'b00, bk_s42.nsq[0]} + {2'b00, bk_s42.nsq[1]}
			+ {2'b00, bk_s42.nsq[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_s43.tag.vld <= 1'b0;
		end else begin
			bk_s43 <= sum_nxt;
		end
	end

	// square root, one root bit per stage
	back_t             sq_bk_s   [SQ_STEPS];
	logic [35:0]       sq_rem_s  [SQ_STEPS];
	logic [ROOT_W-1:0] sq_root_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		back_t             it;
		logic [35:0]       rem_prev;
		logic [ROOT_W-1:0] root_prev;
		logic [37:0]       t;
		logic [37:0]       c;
		logic [37:0]       d;
		logic              ge;

		if (k == 0) begin : g_first
			assign it = bk_s43;
			assign rem_prev = '0;
			assign root_prev = '0;
		end else begin : g_next
			assign it = sq_bk_s[k-1];
			assign rem_prev = sq_rem_s[k-1];
			assign root_prev = sq_root_s[k-1];
		end

		always_comb begin
			t = {rem_prev, it.ssum[67-2*k -: 2]};
			c = {2'b00, root_prev, 2'b01};
			d = t - c;
			ge = t >= c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_bk_s[k].tag.vld <= 1'b0;
			end else begin
				sq_bk_s[k] <= it;
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k] <= ge ? d[35:0] : t[35:0];
			sq_root_s[k] <= {root_prev[ROOT_W-2:0], ge};
		end
	end

	// unit normal dividers: |n| * 2^16 / length
	logic [ROOT_W-1:0]  len_w;
	back_t              sq_out;
	logic [UNIT_QW-1:0] quo_n [3];

	assign len_w = sq_root_s[SQ_STEPS-1];
	assign sq_out = sq_bk_s[SQ_STEPS-1];

	for (genvar k = 0; k < 3; k++) begin : g_unit_div
		jmu_div_pipe #(.DW(ROOT_W), .QW(UNIT_QW)) u_div (
			.clk    (clk),
			.rem_in ({2'b00, sq_out.nmag[k][32:1]}),
			.feed   ({sq_out.nmag[k][0], 16'h0}),
			.den    (len_w),
			.quo    (quo_n[k])
		);
	end

	// side line beside the unit dividers; length times weight forms on the way
	back_t bd_s [BD_LEN];

	for (genvar k = 0; k < BD_LEN; k++) begin : g_bd
		back_t nxt;
		if (k == 0) begin : g_first
			always_comb begin
				nxt = sq_out;
				nxt.lz = (len_w == '0);
				nxt.wprod = len_w * sq_out.tag.w;
			end
		end else if (k == 1) begin : g_wsat
			logic [48:0] t;
			always_comb begin
				t = bd_s[0].wprod[64:16];
				nxt = bd_s[0];
				nxt.sat2 = (t[48:31] != '0);
				nxt.wj2 = nxt.sat2 ? POS_MAX : t[31:0];
			end
		end else begin : g_copy
			assign nxt = bd_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bd_s[k].tag.vld <= 1'b0;
			end else begin
				bd_s[k] <= nxt;
			end
		end
	end

	// output stage: select by operation, zero on singular
	back_t            fin;
	logic [1:0]       st_w;
	logic [8:0][31:0] m_w;
	logic [31:0]      wj_w;
	logic             done_q;
	logic [1:0]       status_q;
	logic [8:0][31:0] m_q;
	logic [31:0]      wj_q;

	assign fin = bd_s[BD_LEN-1];

	always_comb begin
		logic [31:0] qv;
		qv = '0;
		st_w = ST_OK;
		m_w = '0;
		wj_w = '0;
		case (fin.tag.func)
			FUNC_INV: begin
				if (fin.tag.dz) begin
					st_w = ST_SINGULAR;
				end else begin
					m_w = fin.inv;
					st_w = fin.sat ? ST_SAT : ST_OK;
				end
			end
			FUNC_DET: begin
				if (fin.tag.dz) begin
					st_w = ST_SINGULAR;
				end else begin
					wj_w = fin.wj1;
					st_w = fin.sat ? ST_SAT : ST_OK;
				end
			end
			FUNC_NORM: begin
				if (fin.tag.dz || fin.lz) begin
					st_w = ST_SINGULAR;
				end else begin
					for (int k = 0; k < 3; k++) begin
						qv = {15'h0, quo_n[k]};
						m_w[k] = fin.nneg[k] ? -qv : qv;
					end
					wj_w = fin.wj2;
					st_w = (fin.sat || fin.sat2) ? ST_SAT : ST_OK;
				end
			end
			default: begin
				st_w = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.tag.vld;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= st_w;
		m_q <= m_w;
		wj_q <= wj_w;
	end

	assign done = done_q;
	assign status = status_q;
	assign m00 = m_q[0];
	assign m01 = m_q[1];
	assign m02 = m_q[2];
	assign m10 = m_q[3];
	assign m11 = m_q[4];
	assign m12 = m_q[5];
	assign m20 = m_q[6];
	assign m21 = m_q[7];
	assign m22 = m_q[8];
	assign weighted_jacobian = wj_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for jacobian_metric_unit: directed and random quadrature points,
// results checked against an exact-integer model of the inverse, determinant and normal.
// Depends on jmu_pkg and the RTL of the unit.
`default_nettype none
module tb;
	import jmu_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic signed [199:0] LIM_HI = 200'sd2147483647;
	localparam logic signed [199:0] LIM_LO = -200'sd2147483648;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [1:0]         func;
		logic [1:0]         face;
		logic signed [31:0] j[9];
		logic [30:0]        w;
	} point_t;

	typedef struct {
		logic [1:0]         st;
		logic signed [31:0] m[9];
		logic signed [31:0] wj;
	} metric_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] func = '0;
	logic [1:0] face_select = '0;
	logic signed [31:0] jin [9] = '{default: 0};
	logic [30:0] quad_weight = '0;
	wire busy, done;
	wire [1:0] status;
	wire signed [31:0] mout [9];
	wire signed [31:0] weighted_jacobian;

	metric_t metric_q[$];
	int errors = 0;
	int send_gap_pct = 0;
	int idle_cnt = 0;

	jacobian_metric_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .face_select(face_select),
		.j00(jin[0]), .j01(jin[1]), .j02(jin[2]),
		.j10(jin[3]), .j11(jin[4]), .j12(jin[5]),
		.j20(jin[6]), .j21(jin[7]), .j22(jin[8]),
		.quad_weight(quad_weight), .done(done), .status(status),
		.m00(mout[0]), .m01(mout[1]), .m02(mout[2]),
		.m10(mout[3]), .m11(mout[4]), .m12(mout[5]),
		.m20(mout[6]), .m21(mout[7]), .m22(mout[8]),
		.weighted_jacobian(weighted_jacobian)
	);

	always #6 clk = ~clk;

	// clip to the signed 32-bit range and flag the clip
	function automatic logic signed [31:0] clip32(input logic signed [199:0] v, inout bit sat);
		if (v > LIM_HI) begin
			sat = 1'b1;
			return POS_MAX;
		end
		if (v < LIM_LO) begin
			sat = 1'b1;
			return NEG_MAX;
		end
		return v[31:0];
	endfunction

	// exact metric terms of one point
	function automatic metric_t predict_metric(point_t p);
		logic signed [199:0] a[3][3], cof[3][3], inv[3][3], n[3];
		logic signed [199:0] det, wv, mag, v, len, c, sq;
		metric_t r;
		bit sat;
		int r1, r2, c1, c2;
		r.st = ST_OK;
		r.m = '{default: 0};
		r.wj = 0;
		sat = 1'b0;
		wv = p.w;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				a[i][k] = p.j[i*3+k];
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				r1 = (i + 1) % 3; r2 = (i + 2) % 3;
				c1 = (k + 1) % 3; c2 = (k + 2) % 3;
				cof[i][k] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
			end
		det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
		if (p.func == FUNC_NONE)
			return r;
		if (det == 0) begin
			r.st = ST_SINGULAR;
			return r;
		end
		if (p.func == FUNC_DET) begin
			mag = ((det < 0) ? -det : det) * wv;
			mag = mag >>> 48;
			v = (det < 0) ? -mag : mag;
			r.wj = clip32(v, sat);
		end else begin
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					inv[i][k] = clip32((cof[k][i] <<< 32) / det, sat);
			if (p.func == FUNC_INV) begin
				for (int i = 0; i < 3; i++)
					for (int k = 0; k < 3; k++)
						r.m[i*3+k] = inv[i][k][31:0];
			end else begin
				sq = 0;
				for (int k = 0; k < 3; k++) begin
					case (p.face)
						FACE_ROW2: n[k] = -inv[2][k];
						FACE_ROW1: n[k] = -inv[1][k];
						FACE_SUM:  n[k] = inv[0][k] + inv[1][k] + inv[2][k];
						default:   n[k] = -inv[0][k];
					endcase
					sq = sq + n[k] * n[k];
				end
				len = 0;
				for (int b = 35; b >= 0; b--) begin
					c = len | (200'sd1 <<< b);
					if (c * c <= sq)
						len = c;
				end
				if (len == 0) begin
					r.st = ST_SINGULAR;
					return r;
				end
				for (int k = 0; k < 3; k++) begin
					mag = (n[k] < 0) ? -n[k] : n[k];
					mag = (mag <<< 16) / len;
					v = (n[k] < 0) ? -mag : mag;
					r.m[k] = v[31:0];
				end
				r.wj = clip32((len * wv) >>> 16, sat);
			end
		end
		if (sat)
			r.st = ST_SAT;
		return r;
	endfunction

	// one beat: optional idle gap, then hold start until accepted
	task automatic send_point(point_t p);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		func = p.func;
		face_select = p.face;
		for (int i = 0; i < 9; i++)
			jin[i] = p.j[i];
		quad_weight = p.w;
		do @(posedge clk); while (busy);
		metric_q.push_back(predict_metric(p));
	endtask

	function automatic logic signed [31:0] pick_extreme();
		case ($urandom_range(5))
			0: return 0;
			1: return ONE_Q16;
			2: return -ONE_Q16;
			3: return POS_MAX;
			4: return NEG_MAX;
			default: return $urandom_range(3) - 1;
		endcase
	endfunction

	// random point drawn from one of several matrix shapes
	function automatic point_t random_point();
		point_t p;
		int kind, src;
		p.func = ($urandom_range(19) == 0) ? FUNC_NONE : 2'($urandom_range(2));
		p.face = 2'($urandom_range(3));
		case ($urandom_range(3))
			0: p.w = 31'($urandom);
			1: p.w = '1;
			default: p.w = 31'($urandom_range(131072));
		endcase
		kind = $urandom_range(99);
		for (int i = 0; i < 9; i++) begin
			if (kind < 40)
				p.j[i] = (i % 4 == 0) ? $signed(32'($urandom_range(262144)) - 32'sd131072)
					: $signed(32'($urandom_range(65536)) - 32'sd32768);
			else if (kind < 60)
				p.j[i] = $urandom;
			else if (kind < 75)
				p.j[i] = $signed($urandom | 32'h4000_0000) ^ ($urandom_range(1) ? 32'hC000_0000 : 0);
			else if (kind < 85)
				p.j[i] = pick_extreme();
			else
				p.j[i] = $signed(32'($urandom_range(8)) - 32'sd4);
		end
		// push a share of them toward singular: a row of entries copied from another row or zeroed
		if ($urandom_range(9) == 0) begin
			src = $urandom_range(2);
			for (int k = 0; k < 3; k++)
				p.j[((src + 1) % 3)*3+k] = ($urandom_range(1)) ? p.j[src*3+k] : 0;
		end
		return p;
	endfunction

	function automatic point_t diag_point(logic [1:0] f, logic [1:0] fc,
			logic signed [31:0] d0, logic signed [31:0] d1, logic signed [31:0] d2,
			logic [30:0] w);
		point_t p;
		p.func = f;
		p.face = fc;
		p.w = w;
		p.j = '{default: 0};
		p.j[0] = d0;
		p.j[4] = d1;
		p.j[8] = d2;
		return p;
	endfunction

	// extremes, every operation and face, singular, clipping, unused selector
	task automatic test_directed();
		point_t p;
		for (int f = 0; f < 3; f++)
			send_point(diag_point(2'(f), FACE_ROW2, ONE_Q16, ONE_Q16, ONE_Q16, 31'h10000));
		for (int fc = 0; fc < 4; fc++)
			send_point(diag_point(FUNC_NORM, 2'(fc), ONE_Q16, 2*ONE_Q16, -ONE_Q16, 31'h18000));
		send_point(diag_point(FUNC_INV, FACE_ROW0, 0, ONE_Q16, ONE_Q16, '1));
		send_point(diag_point(FUNC_DET, FACE_ROW0, 0, 0, 0, '1));
		send_point(diag_point(FUNC_NORM, FACE_SUM, ONE_Q16, 0, ONE_Q16, '1));
		send_point(diag_point(FUNC_INV, FACE_ROW2, 1, 1, -1, 0));
		send_point(diag_point(FUNC_NORM, FACE_ROW0, 1, 1, 1, '1));
		send_point(diag_point(FUNC_DET, FACE_ROW0, POS_MAX, POS_MAX, POS_MAX, '1));
		send_point(diag_point(FUNC_DET, FACE_ROW0, NEG_MAX, POS_MAX, POS_MAX, '1));
		send_point(diag_point(FUNC_INV, FACE_ROW0, NEG_MAX, NEG_MAX, NEG_MAX, '1));
		send_point(diag_point(FUNC_NORM, FACE_SUM, POS_MAX, NEG_MAX, POS_MAX, '1));
		send_point(diag_point(FUNC_NONE, FACE_ROW1, ONE_Q16, ONE_Q16, ONE_Q16, '1));
		send_point(diag_point(FUNC_NONE, FACE_ROW0, 0, 0, 0, 0));
		p.func = FUNC_NORM;
		p.face = FACE_SUM;
		p.w = '1;
		p.j = '{default: '1};
		send_point(p);
		p.j = '{default: NEG_MAX};
		p.j[0] = POS_MAX;
		p.j[4] = 0;
		send_point(p);
		p.func = FUNC_INV;
		p.j = '{POS_MAX, NEG_MAX, 1, -1, POS_MAX, NEG_MAX, 0, 1, POS_MAX};
		send_point(p);
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_point(random_point());
	endtask

	// hold the sender until the pipeline has drained, then send 20 random points
	task automatic test_drain_pause();
		@(negedge clk);
		start = 1'b0;
		while (metric_q.size() != 0)
			@(posedge clk);
		test_random(20);
	endtask

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		metric_t e;
		if (arst_n && done) begin
			if (metric_q.size() == 0) begin
				$display("%0t unexpected result: status %0d", $time, status);
				errors++;
			end else begin
				e = metric_q.pop_front();
				if (status !== e.st) begin
					$display("%0t status expected %0d got %0d", $time, e.st, status);
					errors++;
				end
				for (int i = 0; i < 9; i++)
					if (mout[i] !== e.m[i]) begin
						$display("%0t m%0d%0d expected %h got %h", $time, i / 3, i % 3,
							e.m[i], mout[i]);
						errors++;
					end
				if (weighted_jacobian !== e.wj) begin
					$display("%0t weighted_jacobian expected %h got %h", $time, e.wj,
						weighted_jacobian);
					errors++;
				end
			end
		end
	end

	// abort when neither side moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_gap_pct = 0;
		test_directed();
		send_gap_pct = 30;
		test_random(640);
		test_drain_pause();
		send_gap_pct = 70;
		test_random(640);
		send_gap_pct = 0;
		test_random(620);
		@(negedge clk);
		start = 1'b0;
		while (metric_q.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
